[sv/pret_pkg.sv]
// ----------------------------------------------------------------------------
// Position return and equity tracker package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pret_pkg;

   localparam int DefaultReturnFractionBits = 24;

   localparam int PriceWidth  = 32;
   localparam int ReturnWidth = 32;
   localparam int EquityWidth = 48;
   localparam int CostWidth   = 25;
   localparam int CountWidth  = 32;
   localparam int InDataWidth = 72;
   localparam int OutDataWidth = 304;

   // Equity 1.0 in Q16.32.
   localparam logic [EquityWidth-1:0] EquityOne = 48'h0001_0000_0000;

   typedef struct packed {
      logic capture;     // take the input beat, update series state, start bar divide
      logic div_step;    // one quotient bit
      logic latch_bar;   // form the bar return and equity factor
      logic div_trade;   // start the trade return divide
      logic latch_trade; // keep the trade gross return
      logic mul_lo;      // low partial product of the equity
      logic mul_hi;      // high partial product of the equity
      logic commit;      // update equity and load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic first;       // captured beat starts a series
      logic trade;       // captured beat closes a long trade
      logic div_last;    // divider is on its final bit
   } dp_status_type;

endpackage

[sv/pret_controller.sv]
// ----------------------------------------------------------------------------
// Position return and equity tracker controller
// Sequences capture, the divides, the two equity partial products and the
// result hand-off.
// ----------------------------------------------------------------------------
module pret_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  pret_pkg::dp_status_type status,
   output pret_pkg::dp_cmd_type    cmd
);
   import pret_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV_BAR, ST_BAR_RES, ST_DIV_TRADE, ST_TRADE_RES,
      ST_MUL_LO, ST_MUL_HI, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIV_BAR;
            end
         end
         ST_DIV_BAR: begin
            if (status.first) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) state_in = ST_BAR_RES;
            end
         end
         ST_BAR_RES: begin
            cmd.latch_bar = 1'b1;
            if (status.trade) begin
               cmd.div_trade = 1'b1;
               state_in      = ST_DIV_TRADE;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_DIV_TRADE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_TRADE_RES;
         end
         ST_TRADE_RES: begin
            cmd.latch_trade = 1'b1;
            state_in        = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/pret_datapath.sv]
// ----------------------------------------------------------------------------
// Position return and equity tracker datapath
// Series state, trade bookkeeping, a shared restoring divider and a
// two-step equity multiplier.
// ----------------------------------------------------------------------------
module pret_datapath #(
   parameter int RETURN_FRACTION_BITS = pret_pkg::DefaultReturnFractionBits
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [pret_pkg::CostWidth-1:0]        csr_wdata,
   input  logic [pret_pkg::PriceWidth-1:0]       in_close,
   input  logic [pret_pkg::PriceWidth-1:0]       in_date,
   input  logic [1:0]                            in_position,
   input  logic                                  in_first,
   input  logic                                  in_last,
   input  pret_pkg::dp_cmd_type                  cmd,
   output pret_pkg::dp_status_type               status,
   output logic [pret_pkg::OutDataWidth-1:0]     out_data,
   output logic                                  out_trade
);
   import pret_pkg::*;

   localparam int F  = RETURN_FRACTION_BITS;
   localparam int W  = PriceWidth + F;
   localparam int CW = $clog2(W);
   localparam logic [W:0] QuoOne = (W+1)'(1) << F;
   localparam logic [W:0] SatLim = ((W+1)'(1) << F) + ((W+1)'(1) << 31);

   // Configuration and series state.
   logic [CostWidth-1:0]   cost_ff;
   logic [PriceWidth-1:0]  prev_close_ff, prev_date_ff;
   logic [1:0]             prev_pos_ff;
   logic                   trade_open_ff;
   logic [PriceWidth-1:0]  open_price_ff, open_date_ff;
   logic [CountWidth-1:0]  open_index_ff, bar_index_ff, changes_ff;
   logic [EquityWidth-1:0] equity_ff;

   // Per-beat working registers.
   logic [1:0]             pos_ff;
   logic                   changed_ff, first_ff, trade_ff;
   logic [PriceWidth-1:0]  tr_entry_price_ff, tr_exit_price_ff;
   logic [PriceWidth-1:0]  tr_entry_date_ff, tr_exit_date_ff;
   logic [CountWidth-1:0]  tr_hold_ff;
   logic [ReturnWidth-1:0] ret_ff, gross_ff;
   logic [31:0]            factor_ff;
   logic                   factor_zero_ff;
   logic [55:0]            prod_lo_ff, prod_hi_ff;

   // Divider.
   logic [W-1:0]           num_ff, quo_ff;
   logic [PriceWidth-1:0]  den_ff, rem_ff;
   logic [CW-1:0]          cnt_ff;

   logic [OutDataWidth-1:0] out_data_ff;
   logic                    out_trade_ff;

   // Input decode and trade decisions.
   logic [1:0]            pos_in;
   logic                  changed, opens, emit_chg, emit_last;
   logic [CountWidth-1:0] bar_index_in;

   assign pos_in       = (in_position == 2'b01) ? 2'b01 :
                         (in_position == 2'b00) ? 2'b00 : 2'b11;
   assign changed      = (pos_in != prev_pos_ff);
   assign opens        = changed && (pos_in == 2'b01);
   assign emit_chg     = changed && (pos_in != 2'b01) && trade_open_ff;
   assign emit_last    = in_last && (opens || (trade_open_ff && !emit_chg));
   assign bar_index_in = bar_index_ff + 1'b1;

   // Divider step and ratio result.
   logic [PriceWidth:0] rem_sh, rem_sub;
   logic                qbit;
   logic [W:0]          quo_ext;
   logic [ReturnWidth-1:0] ratio;

   assign rem_sh  = {rem_ff, num_ff[W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign qbit    = !rem_sub[PriceWidth];
   assign quo_ext = {1'b0, quo_ff};
   assign ratio   = (den_ff == '0)      ? '0 :
                    (quo_ext >= SatLim) ? 32'h7FFF_FFFF :
                    ReturnWidth'(quo_ext - QuoOne);

   // Bar return and equity factor.
   logic signed [33:0] rr_x, prod_x, ret_x, ret_sat, fac_x;
   assign rr_x    = 34'(signed'(ratio));
   assign prod_x  = (pos_ff == 2'b01) ? rr_x : (pos_ff == 2'b00) ? 34'sd0 : -rr_x;
   assign ret_x   = prod_x - (changed_ff ? signed'({9'b0, cost_ff}) : 34'sd0);
   assign ret_sat = (ret_x > 34'sh0_7FFF_FFFF) ? 34'sh0_7FFF_FFFF :
                    (ret_x < -34'sh0_8000_0000) ? -34'sh0_8000_0000 : ret_x;
   assign fac_x   = ret_sat + (34'sd1 <<< F);

   // Equity update from the two partial products.
   logic [79:0]            total, shifted;
   logic [EquityWidth-1:0] equity_in;
   assign total     = {24'b0, prod_lo_ff} + {prod_hi_ff, 24'b0};
   assign shifted   = total >> F;
   assign equity_in = first_ff        ? EquityOne :
                      factor_zero_ff  ? '0 :
                      (|shifted[79:48]) ? {EquityWidth{1'b1}} : shifted[47:0];

   assign status.first    = first_ff;
   assign status.trade    = trade_ff;
   assign status.div_last = (cnt_ff == CW'(W-1));
   assign out_data  = out_data_ff;
   assign out_trade = out_trade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff       <= '0;
         prev_close_ff <= '0;
         prev_date_ff  <= '0;
         prev_pos_ff   <= '0;
         trade_open_ff <= 1'b0;
         open_price_ff <= '0;
         open_date_ff  <= '0;
         open_index_ff <= '0;
         bar_index_ff  <= '0;
         changes_ff    <= '0;
         equity_ff     <= EquityOne;
      end else begin
         if (csr_wen) cost_ff <= csr_wdata;
         if (cmd.capture) begin
            prev_close_ff <= in_close;
            prev_date_ff  <= in_date;
            if (in_first) begin
               prev_pos_ff   <= '0;
               trade_open_ff <= 1'b0;
               open_price_ff <= '0;
               open_date_ff  <= '0;
               open_index_ff <= '0;
               bar_index_ff  <= '0;
               changes_ff    <= '0;
            end else begin
               prev_pos_ff  <= pos_in;
               bar_index_ff <= bar_index_in;
               if (changed) changes_ff <= changes_ff + 1'b1;
               if (opens) begin
                  open_price_ff <= prev_close_ff;
                  open_date_ff  <= prev_date_ff;
                  open_index_ff <= bar_index_ff;
               end
               trade_open_ff <= (opens || trade_open_ff) && !emit_chg && !emit_last;
            end
         end
         if (cmd.commit) equity_ff <= equity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff     <= pos_in;
         changed_ff <= changed;
         first_ff   <= in_first;
         trade_ff   <= !in_first && (emit_chg || emit_last);
         if (emit_chg) begin
            tr_entry_price_ff <= open_price_ff;
            tr_entry_date_ff  <= open_date_ff;
            tr_exit_price_ff  <= prev_close_ff;
            tr_exit_date_ff   <= prev_date_ff;
            tr_hold_ff        <= bar_index_ff - open_index_ff;
         end else begin
            tr_entry_price_ff <= opens ? prev_close_ff : open_price_ff;
            tr_entry_date_ff  <= opens ? prev_date_ff : open_date_ff;
            tr_exit_price_ff  <= in_close;
            tr_exit_date_ff   <= in_date;
            tr_hold_ff        <= bar_index_in - (opens ? bar_index_ff : open_index_ff);
         end
         num_ff <= {in_close, F'(0)};
         den_ff <= prev_close_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_trade) begin
         num_ff <= {tr_exit_price_ff, F'(0)};
         den_ff <= tr_entry_price_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= qbit ? rem_sub[PriceWidth-1:0] : rem_sh[PriceWidth-1:0];
         quo_ff <= {quo_ff[W-2:0], qbit};
         num_ff <= {num_ff[W-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.latch_bar) begin
         ret_ff         <= ret_sat[31:0];
         factor_ff      <= fac_x[31:0];
         factor_zero_ff <= (fac_x <= 34'sd0);
         gross_ff       <= '0;
      end
      if (cmd.latch_trade) gross_ff <= ratio;
      if (cmd.mul_lo) prod_lo_ff <= 56'(equity_ff[23:0] * factor_ff);
      if (cmd.mul_hi) prod_hi_ff <= 56'(equity_ff[47:24] * factor_ff);
      if (cmd.commit) begin
         out_trade_ff <= trade_ff;
         out_data_ff  <= {
            trade_ff ? gross_ff : 32'b0,
            trade_ff ? tr_hold_ff : 32'b0,
            trade_ff ? tr_exit_price_ff : 32'b0,
            trade_ff ? tr_entry_price_ff : 32'b0,
            trade_ff ? tr_exit_date_ff : 32'b0,
            trade_ff ? tr_entry_date_ff : 32'b0,
            changes_ff,
            equity_in,
            first_ff ? 32'b0 : ret_ff};
      end
   end

endmodule

[sv/position_return_equity_tracker_top.sv]
// ----------------------------------------------------------------------------
// Position return and equity tracker
// Per price bar, computes the strategy return, compounds equity, counts
// position changes and reports completed long trades.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  req_     in         tdata: close, date, position; tuser: first bar; tlast: last bar
//  rsp_     out        tdata: return, equity, counts, trade record; tuser: trade valid
//  csr_     in         transaction cost, written when csr_wen is high
//
// A bar's result is registered after the bar divide, the bar return latch
// and the two equity partial products; a bar that closes a trade also runs
// the trade divide before the products, and a first bar skips all of these.
// The next bar is accepted only once the result is registered. The shared
// restoring divider produces one quotient bit per cycle. Reset is synchronous
// and active high; it gives equity 1.0 and clears all series state. A new bar
// is accepted while the previous result still waits in the output register;
// the block holds its finished result until that register is free.
// ----------------------------------------------------------------------------
module position_return_equity_tracker_top #(
   parameter int RETURN_FRACTION_BITS = pret_pkg::DefaultReturnFractionBits
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration write.
   input  logic                              csr_wen,
   input  logic [pret_pkg::CostWidth-1:0]    csr_wdata,
   // Input bars.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // close_price [31:0], bar_date [63:32], held_position [65:64], zeros above
   input  logic [pret_pkg::InDataWidth-1:0]  req_tdata,
   // first_bar [0]
   input  logic [0:0]                        req_tuser,
   // last_bar
   input  logic                              req_tlast,
   // Results.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bar_return [31:0], equity_value [79:32], change_count [111:80],
   // entry_day [143:112], exit_day [175:144], entry_price [207:176],
   // exit_price [239:208], holding_bars [271:240], trade_gross_return [303:272]
   output logic [pret_pkg::OutDataWidth-1:0] rsp_tdata,
   // trade_valid [0]
   output logic [0:0]                        rsp_tuser
);
   import pret_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          out_trade;

   pret_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath captures the beat fields when the controller accepts it.
   pret_datapath #(
      .RETURN_FRACTION_BITS (RETURN_FRACTION_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .in_close    (req_tdata[31:0]),
      .in_date     (req_tdata[63:32]),
      .in_position (req_tdata[65:64]),
      .in_first    (req_tuser[0]),
      .in_last     (req_tlast),
      .cmd         (cmd),
      .status      (status),
      .out_data    (rsp_tdata),
      .out_trade   (out_trade)
   );

   assign rsp_tuser = out_trade;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Position return and equity tracker testbench
// Drives random and directed price bars through the tracker, predicts each
// result beat from a behavioral model of the series state and compares every
// field of every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;

   import pret_pkg::*;

   localparam int FracBits  = DefaultReturnFractionBits;
   localparam int MaxErrors = 10;
   localparam logic [EquityWidth-1:0] EquityMax = {EquityWidth{1'b1}};

   // One input bar as it is queued for the driver.
   typedef struct packed {
      logic [31:0] close_price;
      logic [31:0] bar_date;
      logic [1:0]  held_position;
      logic        first_bar;
      logic        last_bar;
   } bar_type;

   // One result beat: tdata followed by the trade valid flag.
   typedef struct packed {
      logic [OutDataWidth-1:0] data;
      logic                    trade_valid;
   } result_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_wen;
   logic [CostWidth-1:0]    csr_wdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [InDataWidth-1:0]  req_tdata;
   logic [0:0]              req_tuser;
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [OutDataWidth-1:0] rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    req_tready_seen;

   bar_type    pending_bars[$];
   result_type expected_results[$];
   int         mismatch_count;
   int         send_idle_pct;
   int         recv_stall_pct;
   bit         stimulus_done;

   // Model state of the series.
   logic [24:0]          cost_q;
   logic [31:0]          m_prev_close;
   logic [31:0]          m_prev_date;
   int                   m_prev_pos;
   bit                   m_trade_open;
   logic [31:0]          m_entry_price;
   logic [31:0]          m_entry_date;
   logic [31:0]          m_entry_index;
   logic [31:0]          m_bar_index;
   logic [EquityWidth-1:0] m_equity;
   logic [31:0]          m_changes;

   position_return_equity_tracker_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Clamp a wide signed value into the 32-bit return range.
   function automatic longint clamp_return(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // num / den - 1 in the return format; a zero divisor gives zero.
   function automatic longint price_ratio(logic [31:0] num, logic [31:0] den);
      logic [63:0] q;
      if (den == 0) return 0;
      q = ({32'd0, num} << FracBits) / {32'd0, den};
      return clamp_return(longint'(q) - (longint'(1) << FracBits));
   endfunction

   // Equity times (1 + r), truncated and saturated to the equity range.
   function automatic logic [EquityWidth-1:0] grow_equity(logic [EquityWidth-1:0] eq,
                                                           longint r);
      longint      f;
      logic [63:0] a, b, s, res;
      f = (longint'(1) << FracBits) + r;
      if (f <= 0) return '0;
      a = (64'(eq) >> 24) * 64'(f);
      b = (64'(eq) & 64'hFF_FFFF) * 64'(f);
      s = a + (b >> 24);
      res = s >> (FracBits - 24);
      return (res > 64'(EquityMax)) ? EquityMax : res[EquityWidth-1:0];
   endfunction

   // Advance the model by one bar and return the result beat it causes.
   function automatic result_type track_bar(bar_type bar);
      result_type  r;
      longint      ret;
      int          pos;
      logic [31:0] x_date, x_price, x_index;
      bit          closed;
      r = '0;
      closed = 0;
      if (bar.first_bar) begin
         m_prev_close = bar.close_price;
         m_prev_date = bar.bar_date;
         m_prev_pos = 0;
         m_trade_open = 0;
         m_entry_price = 0;
         m_entry_date = 0;
         m_entry_index = 0;
         m_bar_index = 0;
         m_equity = EquityOne;
         m_changes = 0;
         r.data[79:32] = EquityOne;
         return r;
      end
      pos = (bar.held_position == 2'b01) ? 1 : (bar.held_position == 2'b00 ? 0 : -1);
      m_bar_index = m_bar_index + 1;
      ret = price_ratio(bar.close_price, m_prev_close) * pos;
      if (pos != m_prev_pos) begin
         ret = ret - longint'(cost_q);
         m_changes = m_changes + 1;
         if (pos == 1) begin
            m_trade_open = 1;
            m_entry_price = m_prev_close;
            m_entry_date = m_prev_date;
            m_entry_index = m_bar_index - 1;
         end else if (m_trade_open) begin
            closed = 1;
            x_date = m_prev_date;
            x_price = m_prev_close;
            x_index = m_bar_index - 1;
            m_trade_open = 0;
         end
      end
      if (bar.last_bar && m_trade_open) begin
         closed = 1;
         x_date = bar.bar_date;
         x_price = bar.close_price;
         x_index = m_bar_index;
         m_trade_open = 0;
      end
      if (closed) begin
         r.trade_valid = 1'b1;
         r.data[143:112] = m_entry_date;
         r.data[175:144] = x_date;
         r.data[207:176] = m_entry_price;
         r.data[239:208] = x_price;
         r.data[271:240] = x_index - m_entry_index;
         r.data[303:272] = 32'(price_ratio(x_price, m_entry_price));
      end
      ret = clamp_return(ret);
      m_equity = grow_equity(m_equity, ret);
      m_prev_close = bar.close_price;
      m_prev_date = bar.bar_date;
      m_prev_pos = pos;
      r.data[31:0] = 32'(ret);
      r.data[79:32] = m_equity;
      r.data[111:80] = m_changes;
      return r;
   endfunction

   // Queue a bar and its expected result together.
   task automatic queue_bar(logic [31:0] close_price, logic [31:0] bar_date,
                            logic [1:0] held_position, logic first_bar, logic last_bar);
      bar_type bar;
      bar = '{close_price, bar_date, held_position, first_bar, last_bar};
      pending_bars.insert(pending_bars.size(), bar);
      expected_results.insert(expected_results.size(), track_bar(bar));
   endtask

   // Let all queued bars drain, then wait quietly before returning.
   task automatic wait_drained();
      while (pending_bars.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_cost(logic [24:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      cost_q = value;
   endtask

   // Random price near the previous one, with occasional wild jumps.
   function automatic logic [31:0] next_price(logic [31:0] prev);
      longint p;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(1, 4);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         3: return 0;
         default: begin
            p = longint'(prev) + $signed($urandom_range(0, 2000)) - 1000;
            if (p < 1) p = 1;
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            return p[31:0];
         end
      endcase
   endfunction

   // A well-formed series: first bar, random positions, a last bar.
   task automatic queue_series(int length);
      logic [31:0] price, day;
      logic [1:0]  pos;
      price = $urandom_range(1000, 100000);
      day = $urandom();
      pos = 2'b00;
      queue_bar(price, day, 2'($urandom()), 1'b1, 1'b0);
      for (int i = 1; i < length; i++) begin
         price = next_price(price);
         day = day + 1;
         if ($urandom_range(0, 3) == 0) pos = 2'($urandom());
         queue_bar(price, day, pos, 1'b0, i == length - 1);
      end
   endtask

   // Stimulus and phase control.
   initial begin
      logic [24:0] cost_settings[5];
      cost_settings = '{25'd0, 25'h100_0000, 25'd1, 25'h1_0000, 25'h1FF_FFFF & 25'h100_0000};
      mismatch_count = 0;
      stimulus_done = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      cost_q = 0;
      m_prev_close = 0;
      m_prev_date = 0;
      m_prev_pos = 0;
      m_trade_open = 0;
      m_entry_price = 0;
      m_entry_date = 0;
      m_entry_index = 0;
      m_bar_index = 0;
      m_equity = EquityOne;
      m_changes = 0;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: bars before any first bar see a zero previous close.
      queue_bar(32'd100, 32'd5, 2'b01, 1'b0, 1'b0);
      queue_bar(32'd120, 32'd6, 2'b00, 1'b0, 1'b0);
      // First bar that is also a last bar emits no trade.
      queue_bar(32'd100, 32'd0, 2'b01, 1'b1, 1'b1);
      queue_bar(32'd200, 32'd1, 2'b01, 1'b0, 1'b0);
      queue_bar(32'd50, 32'd2, 2'b10, 1'b0, 1'b0);
      queue_bar(32'd60, 32'd3, 2'b11, 1'b0, 1'b0);
      queue_bar(32'd60, 32'd4, 2'b01, 1'b0, 1'b0);
      queue_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b01, 1'b0, 1'b0);
      queue_bar(32'd1, 32'd7, 2'b10, 1'b0, 1'b0);
      queue_bar(32'hFFFF_FFFF, 32'd8, 2'b01, 1'b0, 1'b0);
      queue_bar(32'd0, 32'd9, 2'b01, 1'b0, 1'b0);
      queue_bar(32'd10, 32'd10, 2'b01, 1'b0, 1'b0);
      // A trade still open at the last bar closes there.
      queue_bar(32'd30, 32'd11, 2'b01, 1'b0, 1'b1);
      // The series carries on after its last bar.
      queue_bar(32'd31, 32'd12, 2'b01, 1'b0, 1'b0);
      // A position change on the last bar with no trade open emits no trade.
      queue_bar(32'd40, 32'd13, 2'b00, 1'b0, 1'b1);
      queue_bar(32'd1, 32'hFFFF_FFFF, 2'b00, 1'b1, 1'b0);
      queue_bar(32'hFFFF_FFFF, 32'd0, 2'b10, 1'b0, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         write_cost(phase < 5 ? cost_settings[phase] : 25'($urandom_range(0, 25'h100_0000)));
         for (int n = 0; n < 120; ) begin
            if ($urandom_range(0, 9) == 0) begin
               // Noise: isolated bars with arbitrary flags.
               queue_bar($urandom(), $urandom(), 2'($urandom()), 1'($urandom()),
                         1'($urandom()));
               n++;
            end else begin
               int len;
               len = $urandom_range(2, 20);
               queue_series(len);
               n += len;
            end
         end
         wait_drained();
      end
      stimulus_done = 1;
   end

   // Driver: presents queued bars, idling at random between beats.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         req_tlast <= 1'b0;
      end else if (!req_tvalid || req_tready_seen) begin
         if (pending_bars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= {6'd0, pending_bars[0].held_position, pending_bars[0].bar_date,
                          pending_bars[0].close_price};
            req_tuser <= pending_bars[0].first_bar;
            req_tlast <= pending_bars[0].last_bar;
            pending_bars.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // The handshake is sampled at the rising edge; the driver acts on it afterward.
   always @(posedge clock) begin
      req_tready_seen <= reset ? 1'b0 : (req_tvalid && req_tready);
   end

   initial rsp_tready = 1'b0;
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitor: compares each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxErrors)
               $display("unexpected result beat %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (want.data !== rsp_tdata || want.trade_valid !== rsp_tuser[0]) begin
               mismatch_count++;
               if (mismatch_count <= MaxErrors) begin
                  $display("mismatch ret exp %h got %h, equity exp %h got %h",
                           want.data[31:0], rsp_tdata[31:0],
                           want.data[79:32], rsp_tdata[79:32]);
                  $display("  changes exp %h got %h, trade exp %b got %b",
                           want.data[111:80], rsp_tdata[111:80],
                           want.trade_valid, rsp_tuser[0]);
                  $display("  record exp %h got %h", want.data[303:112],
                           rsp_tdata[303:112]);
               end
            end
         end
      end
   end

   // Final verdict once every phase has drained.
   initial begin
      wait (stimulus_done);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #(8 * 2_000_000);
      $display("tb_top: errors");
      $finish;
   end

endmodule

[filelist.f]
sv/pret_pkg.sv
sv/pret_controller.sv
sv/pret_datapath.sv
sv/position_return_equity_tracker_top.sv
bench/tb_top.sv
